### rtl/icv6ck_pkg.sv
// ============================================================================
// icv6ck_pkg
// Shared types, constants and the ones' complement fold for the ICMPv6
// checksum engine.
// ============================================================================
`default_nettype none

package icv6ck_pkg;

	// address bytes at the head of every packet (source and destination)
	localparam int unsigned ADDR_BYTES = 32;

	// byte counter holds here: address bytes plus the largest payload count
	localparam logic [16:0] COUNT_LIMIT = 17'(ADDR_BYTES + 65535);

	// next header value after reset (ICMPv6)
	localparam logic [7:0] NEXT_HEADER_RST = 8'd58;

	// ones' complement zero written as all ones
	localparam logic [15:0] SUM_ALL_ONES = 16'hffff;

	// one input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		logic [15:0] folded_sum;
		logic [15:0] checksum_field;
		logic        too_short;
		logic        length_overflow;
	} out_item_t;

	// end-around carry fold of a sum of up to four 16-bit terms
	function automatic logic [15:0] oc_fold(input logic [17:0] s);
		logic [16:0] t;
		logic [16:0] r;
		t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
		r = {1'b0, t[15:0]} + {16'd0, t[16]};
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

### rtl/icv6ck_in_stage.sv
// ============================================================================
// icv6ck_in_stage
// Input register: captures one byte transaction per cycle while it has room,
// and hands it to the accumulator when that stage can take it.
// ============================================================================
`default_nettype none

module icv6ck_in_stage
	import icv6ck_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_item,
	input  wire logic     take,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	logic load;

	// room when empty or when the held transaction moves on this cycle
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

### rtl/icv6ck_accum.sv
// ============================================================================
// icv6ck_accum
// Packet state and result register: pairs bytes into words, keeps the running
// ones' complement sum and byte count, and forms the checksum on the last byte.
// ============================================================================
`default_nettype none

module icv6ck_accum
	import icv6ck_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid_s1,
	input  wire in_item_t item_s1,
	output logic          take,
	input  wire logic [7:0] next_header,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_item_t     out_item
);

	logic [15:0] sum_q;
	logic [16:0] count_q;
	logic [7:0]  high_q;
	logic        odd_q;
	logic        sat_q;

	logic        count_inc;
	logic [16:0] count_nx;
	logic        sat_nx;
	logic [15:0] word;
	logic        short_flag;
	logic [16:0] payload_wide;
	logic [15:0] payload;
	logic [15:0] pair_sum;
	logic [15:0] total;
	logic [15:0] folded;
	logic        emit;

	// a non-last byte never needs the result register, so it always moves on
	assign take = valid_s1 && (!item_s1.last || !out_valid || !out_stall);
	assign emit = take && item_s1.last;

	// byte count with saturation
	assign count_inc = count_q < COUNT_LIMIT;
	assign count_nx  = count_inc ? count_q + 17'd1 : count_q;
	assign sat_nx    = sat_q || !count_inc;

	// big-endian word; an unpaired byte takes a zero low byte
	assign word = odd_q ? {high_q, item_s1.data_byte} : {item_s1.data_byte, 8'h00};

	// running sum with a completed word
	assign pair_sum = oc_fold({2'b00, sum_q} + {2'b00, word});

	// pseudo-header payload length, saturated count already caps at 65535
	assign short_flag   = count_nx < 17'(ADDR_BYTES);
	assign payload_wide = count_nx - 17'(ADDR_BYTES);
	assign payload      = short_flag ? 16'd0 : payload_wide[15:0];

	// final sum of data, length and next header
	assign total  = oc_fold({2'b00, sum_q} + {2'b00, word} + {2'b00, payload}
		+ {10'd0, next_header});
	assign folded = (total == 16'd0) ? SUM_ALL_ONES : total;

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			high_q  <= '0;
			odd_q   <= 1'b0;
			sat_q   <= 1'b0;
		end else if (take) begin
			if (item_s1.last) begin
				sum_q   <= '0;
				count_q <= '0;
				high_q  <= '0;
				odd_q   <= 1'b0;
				sat_q   <= 1'b0;
			end else begin
				count_q <= count_nx;
				sat_q   <= sat_nx;
				if (odd_q) begin
					sum_q  <= pair_sum;
					high_q <= '0;
					odd_q  <= 1'b0;
				end else begin
					high_q <= item_s1.data_byte;
					odd_q  <= 1'b1;
				end
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_item.folded_sum      <= folded;
			out_item.checksum_field  <= ~folded;
			out_item.too_short       <= short_flag;
			out_item.length_overflow <= sat_nx;
		end
	end

	// packet state is clear after a result is formed
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (count_q == 17'd0 && !odd_q && !sat_q && sum_q == 16'd0))
		else $error("packet state not cleared after last byte");

	// a waiting result is never overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !emit)
		else $error("result overwritten while stalled");

	// checksum is the complement of the folded sum
	a_complement: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.checksum_field == ~out_item.folded_sum))
		else $error("checksum field is not the complement of the sum");

	// folded sum never reads as zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.folded_sum != 16'd0))
		else $error("folded sum is zero");

	// a short packet cannot also overflow
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.too_short && out_item.length_overflow))
		else $error("short and overflow flags both set");

endmodule

`default_nettype wire

### rtl/icmpv6_checksum_engine_top.sv
// ============================================================================
// icmpv6_checksum_engine_top
// ICMPv6 checksum over a byte stream with IPv6 pseudo-header.
// ============================================================================
// Takes one byte per cycle: 32 bytes of source and destination address, then
// the ICMPv6 message, with last on the final byte. Each byte is held in the
// input register and is then folded into the running sum; the byte marked
// last passes from the input register to the output register, where its
// result waits to be taken. Throughput is one byte per clock, held back
// only while a result sits in the output register under stall and a further
// last byte waits in the input register. next_header is written through the
// cfg channel, which is always ready, and should only change between packets.
`default_nettype none

module icmpv6_checksum_engine_top
	import icv6ck_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_item,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       take;
	logic [7:0] next_header_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_header_q <= NEXT_HEADER_RST;
		end else if (cfg_valid && cfg_ready) begin
			next_header_q <= cfg_data;
		end
	end

	// input register
	icv6ck_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// accumulator and result register
	icv6ck_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.take        (take),
		.next_header (next_header_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

`default_nettype wire
